@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define PIS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pis assertion failed");
// Check that cond never holds outside reset.
`define PIS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pis forbidden condition seen");
`else
`define PIS_ASSERT(lbl, clk, rst, prop)
`define PIS_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

@@ hdl/pis_pkg.sv @@
package pis_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_KP                 = 3'd0,
      CSR_KI                 = 3'd1,
      CSR_KD                 = 3'd2,
      CSR_SEPARATION_THRESH  = 3'd3,
      CSR_INTEGRAL_LIMIT     = 3'd4
   } csr_index_type;

   // Input word
   typedef struct packed {
      logic signed [15:0] target;
      logic signed [15:0] measure;
   } req_type;

   // Result word
   typedef struct packed {
      logic signed [31:0] drive;
      logic               integrating;
   } rsp_type;

   // Configuration registers
   typedef struct packed {
      logic signed [31:0] kp;
      logic signed [31:0] ki;
      logic signed [31:0] kd;
      logic [16:0]        separation_threshold;
      logic [30:0]        integral_limit;
   } cfg_type;

   // Error stage output: operands for the multipliers
   typedef struct packed {
      logic signed [16:0] error;
      logic signed [17:0] difference;
      logic signed [31:0] integral;
      logic               enable;
      logic               integrating;
   } err_type;

   // Product stage output
   typedef struct packed {
      logic signed [48:0] p_term;
      logic signed [63:0] i_term;
      logic signed [49:0] d_term;
      logic               integrating;
   } term_type;

endpackage

@@ hdl/pis_state.sv @@
`include "assert_macros.svh"

module pis_state (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  pis_pkg::req_type req_q,
   input  pis_pkg::cfg_type cfg,
   output pis_pkg::err_type err_ff
);

   logic signed [16:0] prev_error_ff;
   logic signed [16:0] prev_error_in;
   logic signed [31:0] integral_ff;
   logic signed [31:0] integral_in;
   logic               enable_ff;
   logic               enable_in;
   pis_pkg::err_type   err_in;

   logic signed [16:0] error;
   logic signed [17:0] difference;
   logic [16:0]        magnitude;
   logic               in_band;
   logic signed [32:0] acc;
   logic signed [32:0] limit_pos;
   logic signed [32:0] limit_neg;
   logic signed [32:0] clamped;

   always_comb begin
      error      = $signed({req_q.target[15], req_q.target})
                 - $signed({req_q.measure[15], req_q.measure});
      difference = $signed({error[16], error}) - $signed({prev_error_ff[16], prev_error_ff});
      magnitude  = error[16] ? 17'(-error) : error;
      in_band    = (magnitude <= cfg.separation_threshold);

      acc       = $signed({integral_ff[31], integral_ff}) + $signed({{16{error[16]}}, error});
      limit_pos = $signed({2'b00, cfg.integral_limit});
      limit_neg = -limit_pos;
      if (acc > limit_pos) begin
         clamped = limit_pos;
      end else if (acc < limit_neg) begin
         clamped = limit_neg;
      end else begin
         clamped = acc;
      end

      // integrate only inside the separation band
      prev_error_in = error;
      enable_in     = in_band;
      integral_in   = in_band ? clamped[31:0] : integral_ff;

      err_in.error       = error;
      err_in.difference  = difference;
      err_in.integral    = integral_ff;
      err_in.enable      = enable_ff;
      err_in.integrating = in_band;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
         enable_ff     <= 1'b0;
      end else if (load) begin
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
         enable_ff     <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= err_in;
      end
   end

   `PIS_ASSERT(a_flag_matches_word, clock, reset, load |=> (enable_ff == err_ff.integrating))
   `PIS_ASSERT(a_integral_clamped, clock, reset,
      (load && in_band) |=>
         (($signed({integral_ff[31], integral_ff}) <=
           $signed({2'b00, $past(cfg.integral_limit)})) &&
          ($signed({integral_ff[31], integral_ff}) >=
           $signed(33'd0 - {2'b00, $past(cfg.integral_limit)}))))

endmodule

@@ hdl/pis_mult.sv @@
module pis_mult (
   input  logic              clock,
   input  logic              load,
   input  pis_pkg::err_type  err_q,
   input  pis_pkg::cfg_type  cfg,
   output pis_pkg::term_type term_ff
);

   pis_pkg::term_type term_in;

   // three independent products, registered before the adder
   always_comb begin
      term_in.p_term      = cfg.kp * err_q.error;
      term_in.d_term      = cfg.kd * err_q.difference;
      term_in.i_term      = err_q.enable ? (cfg.ki * err_q.integral) : 64'sd0;
      term_in.integrating = err_q.integrating;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         term_ff <= term_in;
      end
   end

endmodule

@@ hdl/pis_out.sv @@
module pis_out (
   input  logic              clock,
   input  logic              load,
   input  pis_pkg::term_type term_q,
   output pis_pkg::rsp_type  rsp_ff
);

   pis_pkg::rsp_type   rsp_in;
   logic signed [63:0] sum;
   logic signed [47:0] scaled;

   always_comb begin
      sum    = 64'(term_q.p_term) + term_q.i_term + 64'(term_q.d_term);
      // drop fraction bits, rounding toward minus infinity
      scaled = sum[63:16];
      if (scaled[47:31] == {17{scaled[47]}}) begin
         rsp_in.drive = scaled[31:0];
      end else if (scaled[47]) begin
         rsp_in.drive = 32'sh8000_0000;
      end else begin
         rsp_in.drive = 32'sh7FFF_FFFF;
      end
      rsp_in.integrating = term_q.integrating;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ hdl/pid_integral_separation.sv @@
// Positional PID controller with integral separation. Each input word brings a
// target and a measurement; each produces exactly one result word holding the
// saturated drive kp*e + ki*I + kd*(e - e_prev), scaled down by 2^16 with floor
// rounding, and a flag telling whether this sample's |e| was within the
// separation threshold. The integral term uses the integral and enable flag left
// by the previous sample; the integral is then updated and clamped to
// +/- integral_limit only when the flag sets. The block takes one word per
// clock while req_stall is low; each word passes through an input register,
// an error and integral stage whose state loop closes within that stage, a
// stage of three parallel multipliers, and a sum-and-saturate stage that is
// also the output register. Empty stages collapse, so up to four words are
// held while rsp_stall is high before req_stall rises. Gains and limits are
// written through the csr port, which is always ready; write them only while no
// word is in flight. Writes to unused indexes are dropped.
`include "assert_macros.svh"

module pid_integral_separation (
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_stall,
   input  pis_pkg::req_type req_data,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pis_pkg::rsp_type rsp_data,

   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   pis_pkg::cfg_type  cfg_ff;
   pis_pkg::cfg_type  cfg_in;
   pis_pkg::req_type  req_ff;
   pis_pkg::err_type  err_q;
   pis_pkg::term_type term_q;

   // stage valid bits: input, error, product, output
   logic in_valid_ff;
   logic err_valid_ff;
   logic term_valid_ff;
   logic out_valid_ff;

   logic load_in;
   logic load_err;
   logic load_term;
   logic load_out;
   logic free_err;
   logic free_term;
   logic free_out;
   logic in_accept;
   logic out_accept;

   // Configuration writes: always ready, drop unknown indexes.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pis_pkg::CSR_KP:                cfg_in.kp = csr_wdata;
            pis_pkg::CSR_KI:                cfg_in.ki = csr_wdata;
            pis_pkg::CSR_KD:                cfg_in.kd = csr_wdata;
            pis_pkg::CSR_SEPARATION_THRESH: cfg_in.separation_threshold = csr_wdata[16:0];
            pis_pkg::CSR_INTEGRAL_LIMIT:    cfg_in.integral_limit = csr_wdata[30:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline flow: a stage advances when the next one is empty or advancing.
   assign out_accept = out_valid_ff && !rsp_stall;
   assign free_out   = !out_valid_ff || !rsp_stall;
   assign load_out   = term_valid_ff && free_out;
   assign free_term  = !term_valid_ff || load_out;
   assign load_term  = err_valid_ff && free_term;
   assign free_err   = !err_valid_ff || load_term;
   assign load_err   = in_valid_ff && free_err;
   assign req_stall  = in_valid_ff && !load_err;
   assign in_accept  = req_valid && !req_stall;
   assign load_in    = in_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         err_valid_ff  <= 1'b0;
         term_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (load_in || load_err) begin
            in_valid_ff <= load_in;
         end
         if (load_err || load_term) begin
            err_valid_ff <= load_err;
         end
         if (load_term || load_out) begin
            term_valid_ff <= load_term;
         end
         if (load_out || out_accept) begin
            out_valid_ff <= load_out;
         end
      end
   end

   // Hold the input word until the error stage takes it.
   always_ff @(posedge clock) begin
      if (load_in) begin
         req_ff <= req_data;
      end
   end

   pis_state u_state (
      .clock  (clock),
      .reset  (reset),
      .load   (load_err),
      .req_q  (req_ff),
      .cfg    (cfg_ff),
      .err_ff (err_q)
   );

   pis_mult u_mult (
      .clock   (clock),
      .load    (load_term),
      .err_q   (err_q),
      .cfg     (cfg_ff),
      .term_ff (term_q)
   );

   pis_out u_out (
      .clock  (clock),
      .load   (load_out),
      .term_q (term_q),
      .rsp_ff (rsp_data)
   );

   assign rsp_valid = out_valid_ff;

   `PIS_ASSERT(a_count_grows, clock, reset,
      (in_accept && !out_accept) |=>
         ($countones({in_valid_ff, err_valid_ff, term_valid_ff, out_valid_ff}) ==
          $past($countones({in_valid_ff, err_valid_ff, term_valid_ff, out_valid_ff})) + 1))
   `PIS_ASSERT(a_count_shrinks, clock, reset,
      (out_accept && !in_accept) |=>
         ($countones({in_valid_ff, err_valid_ff, term_valid_ff, out_valid_ff}) ==
          $past($countones({in_valid_ff, err_valid_ff, term_valid_ff, out_valid_ff})) - 1))
   `PIS_ASSERT_NEVER(a_stall_only_full, clock, reset,
      req_stall && !(in_valid_ff && err_valid_ff && term_valid_ff && out_valid_ff))

endmodule

@@ tb/sv/pid_integral_separation_test.sv @@
`timescale 1ns / 1ps

module pid_integral_separation_test;

   localparam int CLOCK_HALF = 2;
   localparam int RESET_CYCLES = 2;
   localparam int RANDOM_PHASES = 6;
   localparam int WORDS_PER_PHASE = 110;
   localparam int TAIL_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [31:0] Q_ONE = 32'h0001_0000;
   localparam logic [31:0] GAIN_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] GAIN_MIN = 32'h8000_0000;
   localparam logic [31:0] THRESH_MAX = 32'h0001_FFFF;
   localparam logic [31:0] LIMIT_MAX = 32'h7FFF_FFFF;
   localparam longint DRIVE_MAX = 64'sd2147483647;
   localparam longint DRIVE_MIN = -64'sd2147483648;

   // Indexes past the register list; writes there must leave every setting alone.
   localparam logic [2:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CSR_SPARE_LAST = 3'd7;

   localparam logic [15:0] FIELD_EDGES [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

   typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_CHECK} row_kind_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // One line of the directed script. ROW_CHECK rows carry their own expected word;
   // ROW_SAMPLE rows are checked against the predictor only.
   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   reg_index;
      logic [31:0]  wdata;
      logic [15:0]  target;
      logic [15:0]  measure;
      logic [31:0]  drive;
      logic         integrating;
   } script_row_type;

   localparam int SCRIPT_ROWS = 44;
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // Out of reset all gains are zero: drive stays zero, only a zero error integrates.
      '{ROW_CHECK,  pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd0, 32'sd0, 1'b1},
      '{ROW_CHECK,  pis_pkg::CSR_KP, 32'd0, 16'sd32767, 16'h8000, 32'sd0, 1'b0},
      '{ROW_CHECK,  pis_pkg::CSR_KP, 32'd0, 16'h8000, 16'sd32767, 32'sd0, 1'b0},
      // Unity proportional gain, widest threshold and limit.
      '{ROW_WRITE,  pis_pkg::CSR_KP, Q_ONE, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_SEPARATION_THRESH, THRESH_MAX, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_INTEGRAL_LIMIT, LIMIT_MAX, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_CHECK,  pis_pkg::CSR_KP, 32'd0, 16'sd100, 16'sd50, 32'sd50, 1'b1},
      '{ROW_CHECK,  pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd200, -32'sd200, 1'b1},
      // Smallest gain: the fraction drops with floor rounding.
      '{ROW_WRITE,  pis_pkg::CSR_KP, 32'd1, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_CHECK,  pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd1, -32'sd1, 1'b1},
      '{ROW_CHECK,  pis_pkg::CSR_KP, 32'd0, 16'sd1, 16'sd0, 32'sd0, 1'b1},
      // Largest gains, full-swing errors: drive saturates both ways.
      '{ROW_WRITE,  pis_pkg::CSR_KP, GAIN_MAX, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_KD, GAIN_MAX, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd32767, 16'h8000, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'h8000, 16'sd32767, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_KP, GAIN_MIN, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_KD, GAIN_MIN, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd32767, 16'h8000, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'h8000, 16'sd32767, 32'sd0, 1'b0},
      // Integral only: clamp at the limit; a lowered limit clamps the stored sum at the next in-band sample.
      '{ROW_WRITE,  pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_KD, 32'd0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_KI, Q_ONE, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_INTEGRAL_LIMIT, 32'd100, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd1000, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd1000, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_INTEGRAL_LIMIT, 32'd10, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      // Zero limit pins the integral at zero.
      '{ROW_WRITE,  pis_pkg::CSR_INTEGRAL_LIMIT, 32'd0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, -16'sd5, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd7, 16'sd0, 32'sd0, 1'b0},
      // Separation edge: |error| equal to the threshold integrates, one past does not.
      '{ROW_WRITE,  pis_pkg::CSR_SEPARATION_THRESH, 32'd10, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  pis_pkg::CSR_INTEGRAL_LIMIT, LIMIT_MAX, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd10, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd11, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd10, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd11, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd5, 16'sd5, 32'sd0, 1'b0},
      // Spare indexes: drop the write, settings stay.
      '{ROW_WRITE,  CSR_SPARE_FIRST, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_WRITE,  CSR_SPARE_LAST, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd3, 16'sd0, 32'sd0, 1'b0},
      // Zero threshold: only an exact match integrates.
      '{ROW_WRITE,  pis_pkg::CSR_SEPARATION_THRESH, 32'd0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd0, 16'sd0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, pis_pkg::CSR_KP, 32'd0, 16'sd1, 16'sd0, 32'sd0, 1'b0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pis_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pis_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = '0;
   logic [31:0]      csr_wdata = '0;

   // Settings as last written, widened to 64 bits for exact products.
   longint gain_p = 0;
   longint gain_i = 0;
   longint gain_d = 0;
   longint sep_limit = 0;
   longint clamp_limit = 0;

   // Controller state carried from one sample to the next.
   longint last_error = 0;
   longint integral_acc = 0;
   bit     integral_on = 1'b0;

   pis_pkg::rsp_type expected_outputs [$];
   pis_pkg::rsp_type want;
   int               error_count = 0;
   int               stuck_cycles = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             stall_phase = 0;

   pid_integral_separation DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // Advance the controller by one sample and return the word it should emit.
   // Drive uses the integral and enable left by the previous sample.
   function automatic pis_pkg::rsp_type advance_controller(input pis_pkg::req_type w);
      longint err;
      longint diff;
      longint total;
      longint mag;
      longint acc;
      pis_pkg::rsp_type r;
      err = longint'($signed(w.target)) - longint'($signed(w.measure));
      diff = err - last_error;
      total = gain_p * err + gain_d * diff;
      if (integral_on)
         total += gain_i * integral_acc;
      total = total >>> 16;           // arithmetic shift rounds toward minus infinity
      if (total > DRIVE_MAX)
         total = DRIVE_MAX;
      if (total < DRIVE_MIN)
         total = DRIVE_MIN;
      r.drive = total[31:0];
      mag = (err < 0) ? -err : err;
      if (mag > sep_limit) begin
         integral_on = 1'b0;
      end else begin
         integral_on = 1'b1;
         acc = integral_acc + err;    // exact sum first, clamp after
         if (acc > clamp_limit)
            acc = clamp_limit;
         if (acc < -clamp_limit)
            acc = -clamp_limit;
         integral_acc = acc;
      end
      last_error = err;
      r.integrating = integral_on;
      return r;
   endfunction

   // Gains: extremes, zero, realistic values within +/-32.0, or any bit pattern.
   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return GAIN_MAX;
         1: return GAIN_MIN;
         2: return 32'd0;
         3, 4, 5: return 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
         default: return $urandom();
      endcase
   endfunction

   // Upper bits past the register width are left random on purpose.
   function automatic logic [31:0] pick_threshold();
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return THRESH_MAX;
         2, 3: return $urandom_range(0, 64);
         4, 5: return $urandom_range(0, 2000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return LIMIT_MAX;
         2, 3: return $urandom_range(0, 200);
         4: return $urandom_range(0, 100000);
         default: return $urandom();
      endcase
   endfunction

   // Half of the samples sit near or just past the separation threshold so the
   // integrator and its clamp stay busy; the rest are full-range or edge values.
   function automatic pis_pkg::req_type next_sample();
      int span;
      int e;
      int lo;
      int hi;
      int m;
      pis_pkg::req_type w;
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            w.target = FIELD_EDGES[$urandom_range(0, 3)];
            w.measure = FIELD_EDGES[$urandom_range(0, 3)];
         end
         3, 4, 5, 6, 7, 8, 9: begin
            w = pis_pkg::req_type'($urandom());
         end
         default: begin
            span = (sep_limit + 3 > 32767) ? 32767 : int'(sep_limit) + 3;
            e = int'($urandom_range(0, 2 * span)) - span;
            lo = (e < 0) ? -32768 - e : -32768;
            hi = (e > 0) ? 32767 - e : 32767;
            m = lo + int'($urandom_range(0, hi - lo));
            w.measure = 16'(m);
            w.target = 16'(m + e);
         end
      endcase
      return w;
   endfunction

   // Raise valid with the word at a falling edge, hold until taken, then
   // queue the expected word. Valid is left high for the caller to drop.
   task automatic send_sample(input pis_pkg::req_type w, input bit typed,
                              input pis_pkg::rsp_type typed_out);
      pis_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      predicted = advance_controller(w);
      expected_outputs.push_back(typed ? typed_out : predicted);
      @(negedge clock);
   endtask

   // Write one register and mirror it in the settings. Valid stays high so
   // back-to-back writes never lower and raise it in the same step.
   task automatic write_reg(input logic [2:0] reg_index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (reg_index)
         pis_pkg::CSR_KP: gain_p = longint'($signed(value));
         pis_pkg::CSR_KI: gain_i = longint'($signed(value));
         pis_pkg::CSR_KD: gain_d = longint'($signed(value));
         pis_pkg::CSR_SEPARATION_THRESH: sep_limit = longint'(value[16:0]);
         pis_pkg::CSR_INTEGRAL_LIMIT: clamp_limit = longint'(value[30:0]);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding word; every sample yields
   // exactly one, so an empty queue means the pipeline is empty.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0)
         @(negedge clock);
   endtask

   task automatic load_settings();
      settle_block();
      write_reg(pis_pkg::CSR_KP, pick_gain());
      write_reg(pis_pkg::CSR_KI, pick_gain());
      write_reg(pis_pkg::CSR_KD, pick_gain());
      write_reg(pis_pkg::CSR_SEPARATION_THRESH, pick_threshold());
      write_reg(pis_pkg::CSR_INTEGRAL_LIMIT, pick_limit());
      if ($urandom_range(0, 2) == 0)
         write_reg(3'(CSR_SPARE_FIRST + $urandom_range(0, 2)), $urandom());
      csr_valid <= 1'b0;
   endtask

   // Receiver: switch between no stall, light, heavy and periodic stall runs.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= ((stall_phase % 7) < 3);
      endcase
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word: drive %0d integrating %0b",
                     $time, $signed(rsp_data.drive), rsp_data.integrating);
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_data.drive !== want.drive) begin
               error_count++;
               $display("%0t: drive mismatch: expected %0d actual %0d",
                        $time, $signed(want.drive), $signed(rsp_data.drive));
            end
            if (rsp_data.integrating !== want.integrating) begin
               error_count++;
               $display("%0t: integrating mismatch: expected %0b actual %0b",
                        $time, want.integrating, rsp_data.integrating);
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no handshake on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      script_row_type   row;
      pis_pkg::req_type stim;
      pis_pkg::rsp_type typed_out;
      int               burst_left;
      int               gap;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script: settings only change with the pipeline empty.
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         row = SCRIPT[r];
         if (row.kind == ROW_WRITE) begin
            settle_block();
            write_reg(row.reg_index, row.wdata);
         end else begin
            csr_valid <= 1'b0;
            stim.target = row.target;
            stim.measure = row.measure;
            typed_out.drive = row.drive;
            typed_out.integrating = row.integrating;
            send_sample(stim, row.kind == ROW_CHECK, typed_out);
         end
      end

      // Random phases: fresh settings, then bursts of samples with gaps between.
      burst_left = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_settings();
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
               burst_left = $urandom_range(1, 30);
            end
            burst_left--;
            typed_out = '0;
            send_sample(next_sample(), 1'b0, typed_out);
         end
      end

      // Drain, then leave room for any stray word before deciding.
      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/pis_pkg.sv
hdl/pis_state.sv
hdl/pis_mult.sv
hdl/pis_out.sv
hdl/pid_integral_separation.sv
tb/sv/pid_integral_separation_test.sv
